// ===== rtl/vptd_pkg.sv =====
// vptd_pkg: shared constants, types and the divisor function for the tick divider bank
// depends on nothing; used by vptd_chan, the top level and its checker

package vptd_pkg;

	localparam int CHANNELS = 4;

	localparam int FUNC_W   = 3;
	localparam int CHAN_W   = 2;
	localparam int FREQ_W   = 16;
	localparam int STATUS_W = 2;
	localparam int MASK_W   = 4;
	localparam int DIV_W    = 10;

	// operation codes
	localparam logic [FUNC_W-1:0] FN_TICK    = 3'd0;
	localparam logic [FUNC_W-1:0] FN_OPEN    = 3'd1;
	localparam logic [FUNC_W-1:0] FN_CLOSE   = 3'd2;
	localparam logic [FUNC_W-1:0] FN_SETFREQ = 3'd3;
	localparam logic [FUNC_W-1:0] FN_CONSUME = 3'd4;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_REJECT   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOTREADY = 2'd2;

	localparam logic [FREQ_W-1:0] MIN_FREQ     = 16'd2;
	localparam logic [FREQ_W-1:0] BASE_HZ      = 16'd1024;
	localparam logic [DIV_W-1:0]  OPEN_DIVISOR = 10'd512;

	// per-channel command for one transaction
	typedef struct packed {
		logic             tick;
		logic             open;
		logic             close;
		logic             set_div;
		logic             consume;
		logic [DIV_W-1:0] div;
	} chan_cmd_t;

	// per-channel pending flag, now and after this cycle
	typedef struct packed {
		logic pending_q;
		logic pending_d;
	} chan_stat_t;

	// 1024 / (request clipped to 1024, rounded down to a power of two); request >= 2
	function automatic logic [DIV_W-1:0] divisor_for(input logic [FREQ_W-1:0] freq);
		logic [DIV_W-1:0] d;
		d = OPEN_DIVISOR;
		if (freq >= BASE_HZ) begin
			d = 10'd1;
		end else begin
			// highest set bit among 1..9 wins
			for (int k = 1; k < DIV_W; k++) begin
				if (freq[k]) begin
					d = 10'd1 << (DIV_W - k);
				end
			end
		end
		return d;
	endfunction

endpackage

// ===== rtl/vptd_chan.sv =====
// vptd_chan: state of one divider channel (open flag, divisor, counter, pending flag)
// depends on vptd_pkg for the command and status structs

module vptd_chan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  vptd_pkg::chan_cmd_t   cmd,
	output vptd_pkg::chan_stat_t  stat
);

	logic                      open_q;
	logic [vptd_pkg::DIV_W-1:0] div_q;
	logic [vptd_pkg::DIV_W-1:0] count_q;
	logic                      pending_q;

	logic [vptd_pkg::DIV_W-1:0] count_inc;
	logic                      reached;
	logic                      pending_d;

	assign count_inc = count_q + 10'd1;
	assign reached   = (count_inc >= div_q);

	always_comb begin
		pending_d = pending_q;
		if (cmd.close || cmd.consume) begin
			pending_d = 1'b0;
		end else if (cmd.tick && open_q && reached) begin
			pending_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q    <= 1'b0;
			div_q     <= '0;
			count_q   <= '0;
			pending_q <= 1'b0;
		end else begin
			pending_q <= pending_d;
			if (cmd.close) begin
				open_q  <= 1'b0;
				div_q   <= '0;
				count_q <= '0;
			end else if (cmd.open) begin
				open_q <= 1'b1;
				div_q  <= vptd_pkg::OPEN_DIVISOR;
			end else if (cmd.set_div) begin
				div_q <= cmd.div;
			end else if (cmd.tick && open_q) begin
				count_q <= reached ? '0 : count_inc;
			end
		end
	end

	assign stat.pending_q = pending_q;
	assign stat.pending_d = pending_d;

endmodule

// ===== rtl/virtual_periodic_tick_divider_bank_core.sv =====
// virtual_periodic_tick_divider_bank_core: bank of channels dividing a 1024 Hz base tick
// depends on vptd_pkg and vptd_chan
//
// usage
//   command channel: a transaction is taken at a rising edge with start high and busy low;
//   busy stays low, so a new command can be issued every cycle
//   func selects base tick, open, close, set frequency or consume tick; channel names the
//   target channel (ignored for a base tick); frequency is used by set frequency only
//   result channel: done is high for exactly one cycle per command, with status and
//   pending_mask valid in that cycle; the receiver cannot stall it
// pipeline and throughput
//   the command is captured in an input register; all channels are updated and the result
//   is captured in a result register on the next edge, and done goes high with the result;
//   throughput is one command per cycle
//   each channel updates its own counter in parallel, so a base tick costs one pass
// reset
//   arst_n clears every channel (closed, divisor and counter zero, no tick pending) and
//   drops any command in flight
// status codes: ok, frequency below 2 rejected, no tick pending on consume

module virtual_periodic_tick_divider_bank_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [vptd_pkg::FUNC_W-1:0]      func,
	input  logic [vptd_pkg::CHAN_W-1:0]      channel,
	input  logic [vptd_pkg::FREQ_W-1:0]      frequency,
	output logic                             done,
	output logic [vptd_pkg::STATUS_W-1:0]    status,
	output logic [vptd_pkg::MASK_W-1:0]      pending_mask
);

	// input register
	logic                          valid_s1;
	logic [vptd_pkg::FUNC_W-1:0]   func_s1;
	logic [vptd_pkg::CHAN_W-1:0]   channel_s1;
	logic [vptd_pkg::FREQ_W-1:0]   frequency_s1;

	// result register
	logic                          done_s2;
	logic [vptd_pkg::STATUS_W-1:0] status_s2;
	logic [vptd_pkg::MASK_W-1:0]   pending_mask_s2;

	logic                          freq_ok;
	logic [vptd_pkg::DIV_W-1:0]    new_div;
	logic [vptd_pkg::CHANNELS-1:0] sel;
	logic [vptd_pkg::CHANNELS-1:0] pend_now;
	logic                          consume_hit;
	logic [vptd_pkg::STATUS_W-1:0] status_d;
	logic [vptd_pkg::MASK_W-1:0]   mask_d;

	vptd_pkg::chan_cmd_t  cmd  [vptd_pkg::CHANNELS];
	vptd_pkg::chan_stat_t stat [vptd_pkg::CHANNELS];

	// never holds off a command
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			func_s1      <= func;
			channel_s1   <= channel;
			frequency_s1 <= frequency;
		end
	end

	assign freq_ok = (frequency_s1 >= vptd_pkg::MIN_FREQ);
	assign new_div = vptd_pkg::divisor_for(frequency_s1);

	// one command decoder and one cell per channel
	for (genvar i = 0; i < vptd_pkg::CHANNELS; i++) begin : g_chan
		assign sel[i] = valid_s1 && (int'(channel_s1) == i);

		always_comb begin
			cmd[i].tick    = valid_s1 && (func_s1 == vptd_pkg::FN_TICK);
			cmd[i].open    = sel[i] && (func_s1 == vptd_pkg::FN_OPEN);
			cmd[i].close   = sel[i] && (func_s1 == vptd_pkg::FN_CLOSE);
			cmd[i].set_div = sel[i] && (func_s1 == vptd_pkg::FN_SETFREQ) && freq_ok;
			cmd[i].consume = sel[i] && (func_s1 == vptd_pkg::FN_CONSUME) && stat[i].pending_q;
			cmd[i].div     = new_div;
		end

		vptd_chan u_chan (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd[i]),
			.stat   (stat[i])
		);

		assign pend_now[i] = stat[i].pending_q;
	end

	// channels past the bank read as never pending
	for (genvar m = 0; m < vptd_pkg::MASK_W; m++) begin : g_mask
		if (m < vptd_pkg::CHANNELS) begin : g_present
			assign mask_d[m] = stat[m].pending_d;
		end else begin : g_absent
			assign mask_d[m] = 1'b0;
		end
	end

	// an absent channel never matches sel, so consume reports not ready
	assign consume_hit = |(sel & pend_now);

	always_comb begin
		unique case (func_s1)
			vptd_pkg::FN_SETFREQ: status_d = freq_ok ? vptd_pkg::ST_OK : vptd_pkg::ST_REJECT;
			vptd_pkg::FN_CONSUME: status_d = consume_hit ? vptd_pkg::ST_OK
			                                             : vptd_pkg::ST_NOTREADY;
			default:              status_d = vptd_pkg::ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			status_s2       <= status_d;
			pending_mask_s2 <= mask_d;
		end
	end

	assign done         = done_s2;
	assign status       = status_s2;
	assign pending_mask = pending_mask_s2;

endmodule

// ===== rtl/vptd_checker.sv =====
// vptd_checker: port-level assertions for the tick divider bank, bound to the top level
// depends on vptd_pkg and virtual_periodic_tick_divider_bank_core

module vptd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic [vptd_pkg::FUNC_W-1:0]   func,
	input logic                          done,
	input logic [vptd_pkg::STATUS_W-1:0] status
);

	// every accepted transaction gives a result once it has passed the input and result registers
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("accepted transaction produced no result");

	// no result without an earlier accepted transaction
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without a transaction");

	// a reject only answers a set frequency command
	a_reject_src: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == vptd_pkg::ST_REJECT) |-> $past(func == vptd_pkg::FN_SETFREQ, 2))
		else $error("reject status on a command other than set frequency");

	// not ready only answers a consume command
	a_notready_src: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == vptd_pkg::ST_NOTREADY) |-> $past(func == vptd_pkg::FN_CONSUME, 2))
		else $error("not ready status on a command other than consume");

endmodule

bind virtual_periodic_tick_divider_bank_core vptd_checker u_vptd_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.func   (func),
	.done   (done),
	.status (status)
);

// ===== tb/virtual_periodic_tick_divider_bank_core_tb.sv =====
// virtual_periodic_tick_divider_bank_core_tb: self-checking bench for the tick divider bank
// depends on vptd_pkg and the rtl of virtual_periodic_tick_divider_bank_core
// an in-bench model of the four channels predicts status and pending mask for every command

module virtual_periodic_tick_divider_bank_core_tb;

	import vptd_pkg::*;

	// func codes with no operation behind them
	localparam logic [FUNC_W-1:0] FN_SPARE_0 = 3'd5;
	localparam logic [FUNC_W-1:0] FN_SPARE_1 = 3'd6;
	localparam logic [FUNC_W-1:0] FN_SPARE_2 = 3'd7;

	localparam int RESET_CYCLES   = 9;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int MAX_REPORTS    = 10;
	localparam int PHASE_ITEMS    = 510;

	// what one command should produce
	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [MASK_W-1:0]   mask;
	} step_outcome_t;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                start        = 1'b0;
	logic                busy;
	logic [FUNC_W-1:0]   func         = FN_TICK;
	logic [CHAN_W-1:0]   channel      = '0;
	logic [FREQ_W-1:0]   frequency    = '0;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic [MASK_W-1:0]   pending_mask;

	// model copy of the channel bank
	logic             ch_open [CHANNELS];
	logic [DIV_W-1:0] ch_div  [CHANNELS];
	logic [DIV_W-1:0] ch_cnt  [CHANNELS];
	logic             ch_pend [CHANNELS];

	step_outcome_t outcome_q[$];
	int            mismatches    = 0;
	int            quiet_cycles  = 0;
	int            send_idle_pct = 0;

	virtual_periodic_tick_divider_bank_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.channel      (channel),
		.frequency    (frequency),
		.done         (done),
		.status       (status),
		.pending_mask (pending_mask)
	);

	always #10 clk = ~clk;

	// clamp to the base rate, drop to a power of two, divide the base rate by it
	function automatic logic [DIV_W-1:0] rate_to_divisor(input logic [FREQ_W-1:0] hz);
		int          p;
		int          f;
		logic [10:0] q;
		p = 1024;
		f = (hz > BASE_HZ) ? int'(BASE_HZ) : int'(hz);
		while (p > f) begin
			p = p >> 1;
		end
		q = 11'(1024 / p);
		return q[DIV_W-1:0];
	endfunction

	// advance the model by one command and return what the block should report
	function automatic step_outcome_t bank_step(input logic [FUNC_W-1:0] f,
		input logic [CHAN_W-1:0] c, input logic [FREQ_W-1:0] fr);
		step_outcome_t    o;
		logic [DIV_W-1:0] nxt;
		logic             present;
		o.status = ST_OK;
		present  = (int'(c) < CHANNELS);
		case (f)
			FN_TICK: begin
				for (int i = 0; i < CHANNELS; i++) begin
					if (ch_open[i]) begin
						// 10-bit counter wraps like the hardware register
						nxt = ch_cnt[i] + 1'b1;
						if (nxt >= ch_div[i]) begin
							ch_pend[i] = 1'b1;
							ch_cnt[i]  = '0;
						end else begin
							ch_cnt[i] = nxt;
						end
					end
				end
			end
			FN_OPEN: begin
				// counter and pending flag survive a reopen
				if (present) begin
					ch_open[c] = 1'b1;
					ch_div[c]  = OPEN_DIVISOR;
				end
			end
			FN_CLOSE: begin
				if (present) begin
					ch_open[c] = 1'b0;
					ch_div[c]  = '0;
					ch_cnt[c]  = '0;
					ch_pend[c] = 1'b0;
				end
			end
			FN_SETFREQ: begin
				// rejection does not depend on the channel existing
				if (fr < MIN_FREQ) begin
					o.status = ST_REJECT;
				end else if (present) begin
					ch_div[c] = rate_to_divisor(fr);
				end
			end
			FN_CONSUME: begin
				if (present && ch_pend[c]) begin
					ch_pend[c] = 1'b0;
				end else begin
					o.status = ST_NOTREADY;
				end
			end
			default: begin
			end
		endcase
		o.mask = '0;
		for (int i = 0; i < CHANNELS && i < MASK_W; i++) begin
			o.mask[i] = ch_pend[i];
		end
		return o;
	endfunction

	// one command transaction: optional idle cycles, then hold start until taken
	task automatic send_op(input logic [FUNC_W-1:0] f, input logic [CHAN_W-1:0] c,
		input logic [FREQ_W-1:0] fr);
		step_outcome_t o;
		while ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start     <= 1'b1;
		func      <= f;
		channel   <= c;
		frequency <= fr;
		// busy looked at mid-cycle is what the next edge will see
		@(negedge clk);
		while (busy) begin
			@(negedge clk);
		end
		@(posedge clk);
		o = bank_step(f, c, fr);
		outcome_q.push_back(o);
	endtask

	task automatic note_mismatch(input string what, input int exp_val, input int got_val);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("mismatch on %s: expected %0d, got %0d", what, exp_val, got_val);
		end
	endtask

	// frequency mix: mostly fast rates that round down to a high power of two so channels fire often,
	// plus rejects, clipped rates and fully random words
	function automatic logic [FREQ_W-1:0] pick_frequency();
		int          r;
		int          k;
		logic [15:0] lo;
		r = $urandom_range(99);
		if (r < 8) begin
			return FREQ_W'($urandom_range(1));
		end else if (r < 20) begin
			return FREQ_W'($urandom_range(65535));
		end else if (r < 30) begin
			return FREQ_W'($urandom_range(65535, 1025));
		end
		k  = ($urandom_range(99) < 70) ? 10 - $urandom_range(3) : $urandom_range(10, 1);
		lo = 16'($urandom) & ((16'd1 << k) - 16'd1);
		return (16'd1 << k) | lo;
	endfunction

	// first checks straight after reset: nothing open, nothing pending
	task automatic test_after_reset();
		send_op(FN_CONSUME, 2'd0, 16'd0);
		send_op(FN_CONSUME, 2'd3, 16'hFFFF);
		send_op(FN_TICK, 2'd2, 16'd0);
	endtask

	// open, speed up, tick, consume, consume once too often; then channel 1 at 512 Hz over two ticks
	task automatic test_tick_and_consume();
		send_op(FN_OPEN, 2'd0, 16'd0);
		send_op(FN_SETFREQ, 2'd0, 16'd1024);
		send_op(FN_TICK, 2'd0, 16'd0);
		send_op(FN_CONSUME, 2'd0, 16'd0);
		send_op(FN_CONSUME, 2'd0, 16'd0);
		send_op(FN_OPEN, 2'd1, 16'd0);
		send_op(FN_SETFREQ, 2'd1, 16'd512);
		send_op(FN_TICK, 2'd1, 16'd0);
		send_op(FN_TICK, 2'd1, 16'd0);
		send_op(FN_CONSUME, 2'd1, 16'd0);
	endtask

	// rejects below 2, rounding down, clipping at the base rate, closed channels
	task automatic test_freq_rounding();
		send_op(FN_SETFREQ, 2'd2, 16'd0);
		send_op(FN_SETFREQ, 2'd2, 16'd1);
		send_op(FN_SETFREQ, 2'd2, 16'd2);
		send_op(FN_SETFREQ, 2'd3, 16'd1023);
		send_op(FN_SETFREQ, 2'd3, 16'd1025);
		send_op(FN_SETFREQ, 2'd3, 16'hFFFF);
	endtask

	// close a channel holding a pending tick, then the spare func codes
	task automatic test_close_and_unused();
		send_op(FN_TICK, 2'd0, 16'd0);
		send_op(FN_CLOSE, 2'd0, 16'd0);
		send_op(FN_SPARE_0, 2'd3, 16'hFFFF);
		send_op(FN_SPARE_1, 2'd1, 16'd1);
		send_op(FN_SPARE_2, 2'd2, 16'h8000);
	endtask

	// weighted mix: tick heavy, opens outnumber closes so channels stay alive
	task automatic test_random_traffic(input int count);
		int               r;
		logic [FUNC_W-1:0] f;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			if (r < 42) begin
				f = FN_TICK;
			end else if (r < 60) begin
				f = FN_CONSUME;
			end else if (r < 74) begin
				f = FN_SETFREQ;
			end else if (r < 86) begin
				f = FN_OPEN;
			end else if (r < 93) begin
				f = FN_CLOSE;
			end else begin
				f = FN_SPARE_0 + FUNC_W'($urandom_range(2));
			end
			send_op(f, CHAN_W'($urandom_range(3)), pick_frequency());
		end
	endtask

	// result checker and watchdog, sampled on the clock edge
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", quiet_cycles);
				$display("RESULT: ERROR");
				$finish;
			end
			if (done) begin
				if (outcome_q.size() == 0) begin
					note_mismatch("unexpected result, status", -1, int'(status));
				end else begin
					if (status !== outcome_q[0].status) begin
						note_mismatch("status", int'(outcome_q[0].status), int'(status));
					end
					if (pending_mask !== outcome_q[0].mask) begin
						note_mismatch("pending_mask", int'(outcome_q[0].mask),
							int'(pending_mask));
					end
					void'(outcome_q.pop_front());
				end
			end
		end
	end

	initial begin
		// model matches the cleared bank
		for (int i = 0; i < CHANNELS; i++) begin
			ch_open[i] = 1'b0;
			ch_div[i]  = '0;
			ch_cnt[i]  = '0;
			ch_pend[i] = 1'b0;
		end
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed part and first random phase with a sender idling now and then
		send_idle_pct = 27;
		test_after_reset();
		test_tick_and_consume();
		test_freq_rounding();
		test_close_and_unused();
		test_random_traffic(PHASE_ITEMS);

		// sparser sender
		send_idle_pct = 47;
		test_random_traffic(PHASE_ITEMS);

		// back to back, one transaction per cycle
		send_idle_pct = 0;
		test_random_traffic(PHASE_ITEMS);

		start <= 1'b0;
		while (outcome_q.size() != 0) begin
			@(posedge clk);
		end
		// catch any stray strobe after the last result
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outcome_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
